// File: src/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared constants, codes and controller/datapath interface types for the
// fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

    // default parameter values
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int ADDR_WIDTH_DEF = 32;

    // field widths
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FADDR_W    = 32;
    localparam int BADDR_W    = 32;
    localparam int USED_W     = 9;
    localparam int NUM_BLK_W  = 9;
    localparam int SHIFT_W    = 5;
    localparam int BASE_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // item modes
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REINIT = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd2;

    // configuration reset values
    localparam logic [NUM_BLK_W-1:0] NUM_BLOCKS_RST  = 9'd256;
    localparam logic [SHIFT_W-1:0]   BLOCK_SHIFT_RST = 5'd4;
    localparam logic [BASE_W-1:0]    BASE_ADDR_RST   = 32'd0;

    // largest block shift honoured
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;

    // controller to datapath commands
    typedef struct packed {
        logic load;         // capture item, read link of head
        logic start_clear;  // latch pool size, reset head and count
        logic clear_step;   // write one link entry of the chain
        logic commit;       // finish item, update state, load result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;   // current clear step writes the last entry
    } t_dp_sts;

endpackage

// File: src/fbfl_ctrl.sv
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencing state machine: input and output handshakes, clearing pass and
// item completion.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [fbfl_pkg::MODE_W-1:0]   i_mode,
    output logic                          o_valid,
    input  logic                          i_stall,
    output fbfl_pkg::t_dp_cmd             o_cmd,
    input  fbfl_pkg::t_dp_sts             i_sts
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   r_clr_reply;   // clearing pass owes a result

    logic accept;
    logic out_take;
    logic out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || out_take;

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = accept;
        o_cmd.start_clear = accept && (i_mode == fbfl_pkg::MODE_REINIT);
        o_cmd.clear_step  = (r_state == S_CLEAR);
        o_cmd.commit      = (r_state == S_EXEC) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_reply <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_mode == fbfl_pkg::MODE_REINIT) begin
                            r_state     <= S_CLEAR;
                            r_clr_reply <= 1'b1;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_CLEAR: begin
                    if (i_sts.clear_last) begin
                        r_clr_reply <= 1'b0;
                        r_state     <= r_clr_reply ? S_EXEC : S_IDLE;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/fbfl_dp.sv
// ----------------------------------------------------------------------------
// fbfl_dp
// Datapath: configuration registers, link memory, free list head, used
// count, address arithmetic and result register.
// ----------------------------------------------------------------------------
module fbfl_dp #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_WIDTH = fbfl_pkg::ADDR_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [fbfl_pkg::MODE_W-1:0]       i_mode,
    input  logic [fbfl_pkg::FADDR_W-1:0]      i_free_address,
    input  fbfl_pkg::t_dp_cmd                 i_cmd,
    output fbfl_pkg::t_dp_sts                 o_sts,
    output logic [fbfl_pkg::STATUS_W-1:0]     o_status,
    output logic [fbfl_pkg::BADDR_W-1:0]      o_block_address,
    output logic [fbfl_pkg::USED_W-1:0]       o_used_count
);

    localparam int IDXW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PW   = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = (PW > fbfl_pkg::NUM_BLK_W) ? PW : fbfl_pkg::NUM_BLK_W;
    localparam int AW   = ADDR_WIDTH;
    localparam int RST_POOL = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;

    // configuration
    logic [fbfl_pkg::NUM_BLK_W-1:0] r_num_blocks;
    logic [fbfl_pkg::SHIFT_W-1:0]   r_block_shift;
    logic [fbfl_pkg::BASE_W-1:0]    r_base;

    // list state
    logic [IDXW-1:0] r_head;
    logic            r_head_valid;
    logic [PW-1:0]   r_used;
    logic [PW-1:0]   r_pool;
    logic [IDXW-1:0] r_clr_idx;

    // link memory, top bit marks the end of the list
    logic [IDXW:0]   mem [MAX_BLOCKS];
    logic [IDXW:0]   r_rdata;
    logic            mem_we;
    logic [IDXW-1:0] mem_waddr;
    logic [IDXW:0]   mem_wdata;

    // captured item
    logic [fbfl_pkg::MODE_W-1:0]  r_mode;
    logic [fbfl_pkg::FADDR_W-1:0] r_faddr;

    // result
    logic [fbfl_pkg::STATUS_W-1:0] r_status;
    logic [fbfl_pkg::BADDR_W-1:0]  r_baddr;
    logic [fbfl_pkg::USED_W-1:0]   r_used_out;

    logic [CW-1:0]                 num_ext;
    logic [PW-1:0]                 pool_new;
    logic [fbfl_pkg::SHIFT_W-1:0]  sh;
    logic [AW+31:0]                fa_ext;
    logic [AW+31:0]                base_ext;
    logic [AW-1:0]                 fa_aw;
    logic [AW-1:0]                 base_aw;
    logic [AW-1:0]                 off;
    logic [AW-1:0]                 low_mask;
    logic [AW-1:0]                 idx_full;
    logic [AW-1:0]                 alloc_sum;
    logic [AW+31:0]                sum_ext;
    logic                          free_ok;
    logic [IDXW-1:0]               free_idx;
    logic [PW-1:0]                 clr_next;
    logic [PW-1:0]                 n_used;
    logic [PW+8:0]                 used_ext;
    logic [fbfl_pkg::STATUS_W-1:0] n_status;
    logic [fbfl_pkg::BADDR_W-1:0]  n_baddr;

    // pool size clamp: zero taken as one, capped at the memory depth
    always_comb begin
        num_ext = CW'(r_num_blocks);
        if (num_ext == '0) begin
            pool_new = PW'(1);
        end else if (num_ext > CW'(MAX_BLOCKS)) begin
            pool_new = PW'(MAX_BLOCKS);
        end else begin
            pool_new = num_ext[PW-1:0];
        end
    end

    assign sh = (r_block_shift > fbfl_pkg::SHIFT_MAX) ? fbfl_pkg::SHIFT_MAX : r_block_shift;

    // address arithmetic at the internal address width
    assign fa_ext    = {{AW{1'b0}}, r_faddr};
    assign base_ext  = {{AW{1'b0}}, r_base};
    assign fa_aw     = fa_ext[AW-1:0];
    assign base_aw   = base_ext[AW-1:0];
    assign off       = fa_aw - base_aw;
    assign low_mask  = (AW'(1) << sh) - AW'(1);
    assign idx_full  = off >> sh;
    assign free_idx  = idx_full[IDXW-1:0];
    assign free_ok   = ((off & low_mask) == '0) && (idx_full < AW'(r_pool))
                       && (r_used != '0);
    assign alloc_sum = base_aw + (AW'(r_head) << sh);
    assign sum_ext   = {32'b0, alloc_sum};

    // clearing pass chains entry i to i+1
    assign clr_next          = PW'(r_clr_idx) + PW'(1);
    assign o_sts.clear_last  = (clr_next == r_pool);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = {o_sts.clear_last, r_clr_idx + IDXW'(1)};
        if (i_cmd.clear_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.commit && (r_mode == fbfl_pkg::MODE_FREE) && free_ok) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx;
            mem_wdata = {!r_head_valid, r_head};
        end
    end

    // item result and next used count
    always_comb begin
        n_status = fbfl_pkg::ST_OK;
        n_baddr  = '0;
        n_used   = r_used;
        unique case (r_mode)
            fbfl_pkg::MODE_ALLOC: begin
                if (!r_head_valid) begin
                    n_status = fbfl_pkg::ST_EMPTY;
                end else begin
                    n_baddr = sum_ext[31:0];
                    if (r_used != PW'(MAX_BLOCKS)) begin
                        n_used = r_used + PW'(1);
                    end
                end
            end
            fbfl_pkg::MODE_FREE: begin
                if (!free_ok) begin
                    n_status = fbfl_pkg::ST_BAD_FREE;
                end else begin
                    n_used = r_used - PW'(1);
                end
            end
            default: begin
                n_status = fbfl_pkg::ST_OK;
            end
        endcase
    end

    assign used_ext = {9'b0, n_used};

    // configuration and list control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_blocks  <= fbfl_pkg::NUM_BLOCKS_RST;
            r_block_shift <= fbfl_pkg::BLOCK_SHIFT_RST;
            r_base        <= fbfl_pkg::BASE_ADDR_RST;
            r_head        <= '0;
            r_head_valid  <= 1'b1;
            r_used        <= '0;
            r_pool        <= PW'(RST_POOL);
            r_clr_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fbfl_pkg::CFG_NUM_BLOCKS:
                        r_num_blocks <= i_cfg_data[fbfl_pkg::NUM_BLK_W-1:0];
                    fbfl_pkg::CFG_BLOCK_SHIFT:
                        r_block_shift <= i_cfg_data[fbfl_pkg::SHIFT_W-1:0];
                    fbfl_pkg::CFG_BASE_ADDRESS:
                        r_base <= i_cfg_data[fbfl_pkg::BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.start_clear) begin
                r_head       <= '0;
                r_head_valid <= 1'b1;
                r_used       <= '0;
                r_pool       <= pool_new;
                r_clr_idx    <= '0;
            end else if (i_cmd.clear_step) begin
                r_clr_idx <= r_clr_idx + IDXW'(1);
            end else if (i_cmd.commit) begin
                r_used <= n_used;
                if (r_mode == fbfl_pkg::MODE_ALLOC && r_head_valid) begin
                    r_head       <= r_rdata[IDXW-1:0];
                    r_head_valid <= !r_rdata[IDXW];
                end else if (r_mode == fbfl_pkg::MODE_FREE && free_ok) begin
                    r_head       <= free_idx;
                    r_head_valid <= 1'b1;
                end
            end
        end
    end

    // link memory, registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.load) begin
            r_rdata <= mem[r_head];
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_faddr <= i_free_address;
        end
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_baddr    <= n_baddr;
            r_used_out <= used_ext[8:0];
        end
    end

    assign o_status        = r_status;
    assign o_block_address = r_baddr;
    assign o_used_count    = r_used_out;

endmodule

// File: src/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator: pool of equal blocks on a linked free list
// allocate, free, unused mode: registered read of the link memory at the list
// head on accept, commit once the output register has room, input stalled until then
// reinitialize: chain pass of one link entry per cycle, then its result
// after reset: same chain pass over the default pool, input stalled meanwhile
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,  // link memory depth
    parameter int ADDR_WIDTH = fbfl_pkg::ADDR_WIDTH_DEF   // address arithmetic width
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input item channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [fbfl_pkg::MODE_W-1:0]       i_mode,
    input  logic [fbfl_pkg::FADDR_W-1:0]      i_free_address,
    // result item channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [fbfl_pkg::STATUS_W-1:0]     o_status,
    output logic [fbfl_pkg::BADDR_W-1:0]      o_block_address,
    output logic [fbfl_pkg::USED_W-1:0]       o_used_count
);

    // the controller only sequences; every piece of list state, the link
    // memory and the result register live in the datapath
    fbfl_pkg::t_dp_cmd cmd;
    fbfl_pkg::t_dp_sts sts;

    // state machine: clearing pass, idle (takes an item even while a result
    // still waits in the output register), execute (waits for room in the
    // output register, then commits the item)
    fbfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_mode  (i_mode),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // datapath: item capture with link read of the head in the accept cycle,
    // pop or push of the head in the commit cycle, chain writes during the
    // clearing pass; the pool size is latched when a pass starts, block
    // shift and base address are used live
    fbfl_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_free_address  (i_free_address),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_block_address (o_block_address),
        .o_used_count    (o_used_count)
    );

endmodule
